[src/kaau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaau_pkg
// Shared types and constants of the k-means assign and update unit.
// ----------------------------------------------------------------------------
package kaau_pkg;

  localparam int unsigned FEAT_W    = 16;
  localparam int unsigned NUM_FEAT  = 8;
  localparam int unsigned NF_W      = 4;
  localparam int unsigned NC_CFG_W  = 5;
  localparam int unsigned CL_OUT_W  = 4;
  localparam int unsigned SQ_W      = 2 * (FEAT_W + 1);
  localparam int unsigned DIST_W    = SQ_W + $clog2(NUM_FEAT);

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic [NUM_FEAT-1:0][FEAT_W-1:0] fvec_t;

  typedef enum logic [1:0] {
    MODE_WRITE    = 2'd0,
    MODE_ASSIGN   = 2'd1,
    MODE_CLASSIFY = 2'd2,
    MODE_UPDATE   = 2'd3
  } mode_e;

  localparam logic CFG_CLUSTERS = 1'b0;
  localparam logic CFG_FEATURES = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage
`default_nettype wire

[src/kaau_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaau_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kaau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[src/kaau_dist_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaau_dist_lane
// One feature lane: squared difference of a centroid and a sample component.
// ----------------------------------------------------------------------------
module kaau_dist_lane
  import kaau_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [FEAT_W-1:0] cent_i,
  input  wire logic [FEAT_W-1:0] samp_i,
  output logic      [SQ_W-1:0] sq_o
);

  logic [FEAT_W:0] diff;
  logic [FEAT_W:0] mag;
  logic [SQ_W-1:0] mag_ext;

  assign diff    = {cent_i[FEAT_W-1], cent_i} - {samp_i[FEAT_W-1], samp_i};
  assign mag     = diff[FEAT_W] ? (~diff + 1'b1) : diff;
  assign mag_ext = SQ_W'(mag);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_o <= mag_ext * mag_ext;
    end
  end

endmodule
`default_nettype wire

[src/kaau_div_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kaau_div_lane
// One feature lane of the update: restoring division of a signed sum by the
// member count, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kaau_div_lane
  import kaau_pkg::*;
#(
  parameter int unsigned SUM_W   = 40,
  parameter int unsigned COUNT_W = 24
) (
  input  wire logic               clk_i,
  input  wire div_ctrl_t          ctrl_i,
  input  wire logic [SUM_W-1:0]   sum_i,
  input  wire logic [COUNT_W-1:0] count_i,
  output logic      [FEAT_W-1:0]  quo_o
);

  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] den_q;
  logic               neg_q;
  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [FEAT_W-1:0]  low;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign low   = quo_q[FEAT_W-1:0];
  assign quo_o = neg_q ? (~low + 1'b1) : low;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quo_q <= sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
      rem_q <= '0;
      den_q <= count_i;
      neg_q <= sum_i[SUM_W-1];
    end else if (ctrl_i.step) begin
      if (fits) begin
        rem_q <= COUNT_W'(trial - {1'b0, den_q});
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[COUNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[src/kmeans_assign_and_update_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_unit
// Lloyd k-means engine: centroid load, nearest-centroid assignment with
// accumulation, classification and centroid update.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (valid/stall); results leave on the out
// channel through one output register, so a request is taken while a result
// still waits. Configuration writes use cfg_valid_i/cfg_ready_o; the user must
// make them only while the unit is idle; the unit does not enforce this.
// A centroid write gives no result. Assign and classify scan the clusters
// in use one per cycle through the centroid memory port and eight feature
// lanes. An update runs a bit-serial division in the feature lanes for each
// cluster in use, skipped for an empty cluster, and gives one result per
// cluster in use.
// Reset clears the configuration to 16 clusters and 8 features and marks all
// centroids and accumulators as zero; no clearing pass is needed. While the
// receiver stalls, the result is held and the unit waits before its next one.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_unit
  import kaau_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [3:0]          target_cluster_i,
  input  wire logic [FEAT_W-1:0]   feature_0_i,
  input  wire logic [FEAT_W-1:0]   feature_1_i,
  input  wire logic [FEAT_W-1:0]   feature_2_i,
  input  wire logic [FEAT_W-1:0]   feature_3_i,
  input  wire logic [FEAT_W-1:0]   feature_4_i,
  input  wire logic [FEAT_W-1:0]   feature_5_i,
  input  wire logic [FEAT_W-1:0]   feature_6_i,
  input  wire logic [FEAT_W-1:0]   feature_7_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CL_OUT_W-1:0]      chosen_cluster_o,
  output logic [FEAT_W-1:0]        centroid_0_o,
  output logic [FEAT_W-1:0]        centroid_1_o,
  output logic [FEAT_W-1:0]        centroid_2_o,
  output logic [FEAT_W-1:0]        centroid_3_o,
  output logic [FEAT_W-1:0]        centroid_4_o,
  output logic [FEAT_W-1:0]        centroid_5_o,
  output logic [FEAT_W-1:0]        centroid_6_o,
  output logic [FEAT_W-1:0]        centroid_7_o,
  output logic                     empty_cluster_o,
  output logic                     converged_o,
  output logic                     last_result_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [NC_CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CIDX_W = $clog2(MAX_CLUSTERS);
  localparam int unsigned NC_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SUM_W  = FEAT_W + COUNT_WIDTH;
  localparam int unsigned CROW_W = FEAT_W * NUM_FEAT;
  localparam int unsigned AROW_W = SUM_W * NUM_FEAT + COUNT_WIDTH;
  localparam int unsigned DIVC_W = $clog2(SUM_W + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_FETCH = 8'b0000_0100,
    ST_EMIT  = 8'b0000_1000,
    ST_URD   = 8'b0001_0000,
    ST_ULOAD = 8'b0010_0000,
    ST_UDIV  = 8'b0100_0000,
    ST_UEMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [NC_CFG_W-1:0] ncl_cfg_q;
  logic [NF_W-1:0]     nf_cfg_q;
  logic [NC_W-1:0]     nc_eff;
  logic [NF_W-1:0]     nf_eff;
  logic [NUM_FEAT-1:0] fmask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncl_cfg_q <= NC_CFG_W'(16);
      nf_cfg_q  <= NF_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CLUSTERS: ncl_cfg_q <= cfg_data_i;
        CFG_FEATURES: nf_cfg_q  <= cfg_data_i[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ncl_cfg_q == '0) begin
      nc_eff = NC_W'(1);
    end else if (int'(ncl_cfg_q) > MAX_CLUSTERS) begin
      nc_eff = NC_W'(MAX_CLUSTERS);
    end else begin
      nc_eff = NC_W'(ncl_cfg_q);
    end
    if (nf_cfg_q == '0) begin
      nf_eff = NF_W'(1);
    end else if (int'(nf_cfg_q) > NUM_FEAT) begin
      nf_eff = NF_W'(NUM_FEAT);
    end else begin
      nf_eff = nf_cfg_q;
    end
    for (int j = 0; j < NUM_FEAT; j++) begin
      fmask[j] = NF_W'(j) < nf_eff;
    end
  end

  // Input request
  fvec_t in_vec;
  fvec_t samp_q;
  mode_e mode_q;
  logic  accept;

  assign in_vec[0] = feature_0_i;
  assign in_vec[1] = feature_1_i;
  assign in_vec[2] = feature_2_i;
  assign in_vec[3] = feature_3_i;
  assign in_vec[4] = feature_4_i;
  assign in_vec[5] = feature_5_i;
  assign in_vec[6] = feature_6_i;
  assign in_vec[7] = feature_7_i;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= in_vec;
      mode_q <= mode_e'(mode_i);
    end
  end

  // Centroid and accumulator stores
  logic              c_we, a_we;
  logic [CIDX_W-1:0] c_waddr, a_waddr, raddr;
  logic [CROW_W-1:0] c_wdata, c_rdata;
  logic [AROW_W-1:0] a_wdata, a_rdata;
  logic [MAX_CLUSTERS-1:0] cvld_q, avld_q;
  logic              c_rvld_q, a_rvld_q;
  fvec_t             cent_rd;
  logic [AROW_W-1:0] acc_rd;
  logic [COUNT_WIDTH-1:0] acc_cnt;

  kaau_ram #(.WIDTH(CROW_W), .DEPTH(MAX_CLUSTERS)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (raddr),
    .rdata_o (c_rdata)
  );

  kaau_ram #(.WIDTH(AROW_W), .DEPTH(MAX_CLUSTERS)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  // Rows never written read as zero.
  assign cent_rd = c_rvld_q ? fvec_t'(c_rdata) : '0;
  assign acc_rd  = a_rvld_q ? a_rdata : '0;
  assign acc_cnt = acc_rd[NUM_FEAT*SUM_W +: COUNT_WIDTH];

  // Scan pipeline and feature lanes
  logic [NC_W-1:0]   iss_q;
  logic [NC_W-1:0]   upd_q;
  logic              s1_vld_q, s2_vld_q, s1_vld_d;
  logic [CIDX_W-1:0] s1_idx_q, s2_idx_q;
  logic [CIDX_W-1:0] best_q;
  logic [DIST_W-1:0] best_d_q;
  logic [DIST_W-1:0] dist_sum;
  logic [NUM_FEAT-1:0][SQ_W-1:0] sq;

  assign s1_vld_d = (state_q == ST_SCAN) && (iss_q < nc_eff);

  for (genvar j = 0; j < NUM_FEAT; j++) begin : g_dist
    kaau_dist_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (s1_vld_q),
      .cent_i (cent_rd[j]),
      .samp_i (samp_q[j]),
      .sq_o   (sq[j])
    );
  end

  // Merging stage: lane sum and running minimum.
  always_comb begin
    dist_sum = '0;
    for (int j = 0; j < NUM_FEAT; j++) begin
      if (fmask[j]) begin
        dist_sum = dist_sum + DIST_W'(sq[j]);
      end
    end
  end

  always_comb begin
    unique case (state_q) inside
      ST_SCAN:                   raddr = iss_q[CIDX_W-1:0];
      ST_FETCH, ST_EMIT:         raddr = best_q;
      default:                   raddr = upd_q[CIDX_W-1:0];
    endcase
  end

  // Division lanes
  div_ctrl_t div_ctrl;
  logic [DIVC_W-1:0] divc_q;
  logic [NUM_FEAT-1:0][FEAT_W-1:0] quo;

  assign div_ctrl.load = state_q == ST_ULOAD;
  assign div_ctrl.step = state_q == ST_UDIV;

  for (genvar j = 0; j < NUM_FEAT; j++) begin : g_div
    kaau_div_lane #(.SUM_W(SUM_W), .COUNT_W(COUNT_WIDTH)) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (div_ctrl),
      .sum_i   (acc_rd[j*SUM_W +: SUM_W]),
      .count_i (acc_cnt),
      .quo_o   (quo[j])
    );
  end

  fvec_t old_q;
  fvec_t new_vec;
  logic  empty_q, conv_q, changed, last_upd, out_free;

  assign last_upd = upd_q == (nc_eff - NC_W'(1));

  always_comb begin
    changed = 1'b0;
    for (int j = 0; j < NUM_FEAT; j++) begin
      if (fmask[j] && !empty_q) begin
        new_vec[j] = quo[j];
        if (quo[j] != old_q[j]) begin
          changed = 1'b1;
        end
      end else begin
        new_vec[j] = old_q[j];
      end
    end
  end

  // Output register
  logic                out_vld_q;
  logic [CL_OUT_W-1:0] out_cl_q;
  fvec_t               out_cent_q;
  logic                out_empty_q, out_conv_q, out_last_q;
  logic                out_load;
  logic [CL_OUT_W-1:0] out_cl_d;
  fvec_t               out_src;
  logic                out_empty_d, out_conv_d;

  assign out_free = !out_vld_q || !out_stall_i;

  // Accumulator update for an assign request.
  always_comb begin
    a_wdata = acc_rd;
    a_wdata[NUM_FEAT*SUM_W +: COUNT_WIDTH] = acc_cnt + COUNT_WIDTH'(1);
    for (int j = 0; j < NUM_FEAT; j++) begin
      if (fmask[j]) begin
        a_wdata[j*SUM_W +: SUM_W] = acc_rd[j*SUM_W +: SUM_W]
            + {{COUNT_WIDTH{samp_q[j][FEAT_W-1]}}, samp_q[j]};
      end
    end
  end
  assign a_waddr = best_q;

  // Control
  always_comb begin
    state_d     = state_q;
    c_we        = 1'b0;
    c_waddr     = upd_q[CIDX_W-1:0];
    c_wdata     = CROW_W'(new_vec);
    a_we        = 1'b0;
    out_load    = 1'b0;
    out_cl_d    = CL_OUT_W'(upd_q);
    out_src     = new_vec;
    out_empty_d = empty_q;
    out_conv_d  = last_upd && conv_q && !changed;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_e'(mode_i)) inside
            MODE_WRITE: begin
              c_we    = int'(target_cluster_i) < MAX_CLUSTERS;
              c_waddr = CIDX_W'(target_cluster_i);
              c_wdata = CROW_W'(in_vec);
            end
            MODE_ASSIGN, MODE_CLASSIFY: state_d = ST_SCAN;
            MODE_UPDATE:                state_d = ST_URD;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_q == nc_eff && !s1_vld_q && !s2_vld_q) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        out_cl_d    = CL_OUT_W'(best_q);
        out_src     = cent_rd;
        out_empty_d = 1'b0;
        out_conv_d  = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          a_we     = (mode_q == MODE_ASSIGN) && (acc_cnt != COUNT_MAX);
          state_d  = ST_IDLE;
        end
      end
      ST_URD:   state_d = ST_ULOAD;
      ST_ULOAD: state_d = (acc_cnt == '0) ? ST_UEMIT : ST_UDIV;
      ST_UDIV: begin
        if (divc_q == DIVC_W'(1)) begin
          state_d = ST_UEMIT;
        end
      end
      ST_UEMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          c_we     = 1'b1;
          state_d  = last_upd ? ST_IDLE : ST_URD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cvld_q    <= '0;
      avld_q    <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s1_vld_q;
      if (c_we) begin
        cvld_q[c_waddr] <= 1'b1;
      end
      if (a_we) begin
        avld_q[a_waddr] <= 1'b1;
      end
      // The update's last result empties every accumulator at once.
      if (state_q == ST_UEMIT && out_free && last_upd) begin
        avld_q <= '0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_rvld_q <= cvld_q[raddr];
    a_rvld_q <= avld_q[raddr];
    s1_idx_q <= iss_q[CIDX_W-1:0];
    s2_idx_q <= s1_idx_q;
    if (accept) begin
      iss_q  <= '0;
      upd_q  <= '0;
      conv_q <= 1'b1;
    end
    if (s1_vld_d) begin
      iss_q <= iss_q + NC_W'(1);
    end
    if (s2_vld_q && (s2_idx_q == '0 || dist_sum < best_d_q)) begin
      best_q   <= s2_idx_q;
      best_d_q <= dist_sum;
    end
    if (state_q == ST_ULOAD) begin
      old_q   <= cent_rd;
      empty_q <= acc_cnt == '0;
      divc_q  <= DIVC_W'(SUM_W);
    end
    if (state_q == ST_UDIV) begin
      divc_q <= divc_q - DIVC_W'(1);
    end
    if (state_q == ST_UEMIT && out_free) begin
      conv_q <= conv_q && !changed;
      upd_q  <= upd_q + NC_W'(1);
    end
    if (out_load) begin
      out_cl_q    <= out_cl_d;
      out_empty_q <= out_empty_d;
      out_conv_q  <= out_conv_d;
      out_last_q  <= (state_q == ST_EMIT) || last_upd;
      for (int j = 0; j < NUM_FEAT; j++) begin
        out_cent_q[j] <= fmask[j] ? out_src[j] : '0;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign chosen_cluster_o = out_cl_q;
  assign centroid_0_o     = out_cent_q[0];
  assign centroid_1_o     = out_cent_q[1];
  assign centroid_2_o     = out_cent_q[2];
  assign centroid_3_o     = out_cent_q[3];
  assign centroid_4_o     = out_cent_q[4];
  assign centroid_5_o     = out_cent_q[5];
  assign centroid_6_o     = out_cent_q[6];
  assign centroid_7_o     = out_cent_q[7];
  assign empty_cluster_o  = out_empty_q;
  assign converged_o      = out_conv_q;
  assign last_result_o    = out_last_q;

  a_conv_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> last_result_o)
    else $error("converged flag on a result that is not the last");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> iss_q <= nc_eff)
    else $error("scan index ran past the clusters in use");

  a_acc_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_we |-> state_q == ST_EMIT && mode_q == MODE_ASSIGN)
    else $error("accumulator written outside an assign request");

  a_idle_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !s1_vld_q && !s2_vld_q)
    else $error("request taken while the scan pipeline is busy");

endmodule
`default_nettype wire

[dv/kmeans_assign_and_update_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_unit_tb
// Self-checking bench for the k-means assign and update unit. Requests are
// queued by a sequencer, driven by a clocked driver and predicted on
// acceptance; a clocked monitor compares every result with the oldest
// prediction. Phases vary the configuration, idling and output back-pressure.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_unit_tb;
  import kaau_pkg::*;

  localparam int NCL = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam longint unsigned COUNT_MAX = (64'd1 << 24) - 1;

  typedef struct {
    mode_e      mode;
    logic [3:0] target;
    feat_t      f[NUM_FEAT];
  } sample_t;

  typedef struct {
    logic [3:0] cluster;
    feat_t      c[NUM_FEAT];
    logic       empty;
    logic       conv;
    logic       last;
  } centroid_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = CFG_CLUSTERS;
  logic [NC_CFG_W-1:0] cfg_data = '0;
  sample_t drv;

  logic in_stall_o, out_valid_o, cfg_ready_o;
  logic [CL_OUT_W-1:0] chosen_cluster_o;
  logic [FEAT_W-1:0] cent_o[NUM_FEAT];
  logic empty_cluster_o, converged_o, last_result_o;

  sample_t sample_q[$];
  centroid_res_t result_q[$];
  int errors = 0;
  int send_idle = 0;
  int stall_rate = 0;
  bit pressure_on = 0;
  bit pressure_used = 0;
  int hold_left = 0;

  // Predictor state.
  logic [4:0] cfg_clusters = 5'd16;
  logic [3:0] cfg_features = 4'd8;
  feat_t centroids[NCL][NUM_FEAT];
  longint sums[NCL][NUM_FEAT];
  longint unsigned counts[NCL];

  always #2 clk_i = ~clk_i;

  kmeans_assign_and_update_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .mode_i(drv.mode), .target_cluster_i(drv.target),
    .feature_0_i(drv.f[0]), .feature_1_i(drv.f[1]),
    .feature_2_i(drv.f[2]), .feature_3_i(drv.f[3]),
    .feature_4_i(drv.f[4]), .feature_5_i(drv.f[5]),
    .feature_6_i(drv.f[6]), .feature_7_i(drv.f[7]),
    .out_valid_o, .out_stall_i(out_stall),
    .chosen_cluster_o,
    .centroid_0_o(cent_o[0]), .centroid_1_o(cent_o[1]),
    .centroid_2_o(cent_o[2]), .centroid_3_o(cent_o[3]),
    .centroid_4_o(cent_o[4]), .centroid_5_o(cent_o[5]),
    .centroid_6_o(cent_o[6]), .centroid_7_o(cent_o[7]),
    .empty_cluster_o, .converged_o, .last_result_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o,
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic int active_clusters();
    if (cfg_clusters == 0) return 1;
    if (cfg_clusters > NCL) return NCL;
    return int'(cfg_clusters);
  endfunction

  function automatic int active_features();
    if (cfg_features == 0) return 1;
    if (cfg_features > NUM_FEAT) return NUM_FEAT;
    return int'(cfg_features);
  endfunction

  function automatic centroid_res_t centroid_view(int k, int nf, bit empty, bit conv,
                                                  bit last);
    centroid_res_t r;
    r.cluster = k[3:0];
    for (int j = 0; j < NUM_FEAT; j++) r.c[j] = (j < nf) ? centroids[k][j] : '0;
    r.empty = empty;
    r.conv = conv;
    r.last = last;
    return r;
  endfunction

  task automatic queue_sample(sample_t s);
    sample_q.insert(sample_q.size(), s);
  endtask

  task automatic queue_result(centroid_res_t r);
    result_q.insert(result_q.size(), r);
  endtask

  // Works out the results of one accepted request and advances the state.
  task automatic predict_request(sample_t s);
    int nc, nf, best;
    longint unsigned dsq, best_dsq;
    longint diff, q;
    bit conv;
    nc = active_clusters();
    nf = active_features();
    case (s.mode) inside
      MODE_WRITE: begin
        for (int j = 0; j < NUM_FEAT; j++) centroids[s.target][j] = s.f[j];
      end
      MODE_ASSIGN, MODE_CLASSIFY: begin
        best = 0;
        best_dsq = 0;
        for (int i = 0; i < nc; i++) begin
          dsq = 0;
          for (int j = 0; j < nf; j++) begin
            diff = longint'(centroids[i][j]) - longint'(s.f[j]);
            dsq += longint'(diff * diff);
          end
          if (i == 0 || dsq < best_dsq) begin
            best = i;
            best_dsq = dsq;
          end
        end
        queue_result(centroid_view(best, nf, 0, 0, 1));
        if (s.mode == MODE_ASSIGN && counts[best] < COUNT_MAX) begin
          counts[best]++;
          for (int j = 0; j < nf; j++) sums[best][j] += s.f[j];
        end
      end
      default: begin
        conv = 1;
        for (int i = 0; i < nc; i++) begin
          if (counts[i] != 0) begin
            for (int j = 0; j < nf; j++) begin
              q = sums[i][j] / longint'(counts[i]);
              if (q != longint'(centroids[i][j])) conv = 0;
              centroids[i][j] = feat_t'(q);
            end
          end
          queue_result(centroid_view(i, nf, counts[i] == 0,
                                     (i == nc - 1) && conv, i == nc - 1));
        end
        for (int i = 0; i < NCL; i++) begin
          counts[i] = 0;
          for (int j = 0; j < NUM_FEAT; j++) sums[i][j] = 0;
        end
      end
    endcase
  endtask

  // Driver: predicts the request taken at this edge, then offers the next.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) predict_request(drv);
      if (!in_valid || !in_stall_o) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks the result taken at this edge and drives the stall.
  always @(posedge clk_i) begin
    centroid_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result expected none actual cluster %0d", $time,
                   chosen_cluster_o);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (chosen_cluster_o !== want.cluster) begin
            $display("%0t: cluster expected %0d actual %0d", $time, want.cluster,
                     chosen_cluster_o);
            errors++;
          end
          for (int j = 0; j < NUM_FEAT; j++)
            if (cent_o[j] !== want.c[j]) begin
              $display("%0t: centroid_%0d expected %0d actual %0d", $time, j,
                       want.c[j], $signed(cent_o[j]));
              errors++;
            end
          if (empty_cluster_o !== want.empty) begin
            $display("%0t: empty expected %0b actual %0b", $time, want.empty,
                     empty_cluster_o);
            errors++;
          end
          if (converged_o !== want.conv) begin
            $display("%0t: converged expected %0b actual %0b", $time, want.conv,
                     converged_o);
            errors++;
          end
          if (last_result_o !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last,
                     last_result_o);
            errors++;
          end
        end
      end
      if (pressure_on && !pressure_used) begin
        pressure_used <= 1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_rate);
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [NC_CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_CLUSTERS) cfg_clusters = value;
    else cfg_features = value[3:0];
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk_i);
    // A trailing centroid write gives no result; let it settle.
    repeat (50) @(posedge clk_i);
  endtask

  function automatic sample_t make_sample(mode_e m, logic [3:0] t, int fill);
    sample_t s;
    s.mode = m;
    s.target = t;
    for (int j = 0; j < NUM_FEAT; j++) s.f[j] = feat_t'(fill);
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    int spread;
    pick = $urandom_range(99);
    s.mode = (pick < 20) ? MODE_WRITE : (pick < 65) ? MODE_ASSIGN :
             (pick < 88) ? MODE_CLASSIFY : MODE_UPDATE;
    s.target = $urandom_range(15);
    // Mostly small values so that clusters compete; now and then full range.
    spread = ($urandom_range(3) == 0) ? 0 : 400;
    for (int j = 0; j < NUM_FEAT; j++)
      s.f[j] = (spread == 0) ? feat_t'($urandom) :
               feat_t'($urandom_range(2 * spread) - spread);
    return s;
  endfunction

  task automatic run_phase(logic [4:0] nc, logic [4:0] nf, int sidle, int srate,
                           int count, bit squeeze);
    drain();
    write_reg(CFG_CLUSTERS, nc);
    write_reg(CFG_FEATURES, nf);
    send_idle = sidle;
    stall_rate = srate;
    if (squeeze) pressure_on = 1;
    for (int n = 0; n < count; n++) queue_sample(random_sample());
    // Close with an update so the accumulators are exercised each phase.
    queue_sample(make_sample(MODE_UPDATE, 0, 0));
  endtask

  initial begin
    sample_t s;
    for (int j = 0; j < NUM_FEAT; j++) drv.f[j] = '0;
    drv.mode = MODE_WRITE;
    drv.target = '0;
    for (int i = 0; i < NCL; i++) begin
      counts[i] = 0;
      for (int j = 0; j < NUM_FEAT; j++) begin
        centroids[i][j] = '0;
        sums[i][j] = 0;
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at full size.
    write_reg(CFG_CLUSTERS, 5'd16);
    write_reg(CFG_FEATURES, 5'd8);
    queue_sample(make_sample(MODE_UPDATE, 0, 0));       // all empty, converged
    queue_sample(make_sample(MODE_CLASSIFY, 0, 5));     // all tie on zero
    queue_sample(make_sample(MODE_WRITE, 4'd15, 32767));
    queue_sample(make_sample(MODE_WRITE, 4'd3, -32768));
    queue_sample(make_sample(MODE_WRITE, 4'd5, -32768)); // tie with cluster 3
    queue_sample(make_sample(MODE_ASSIGN, 0, 32767));
    queue_sample(make_sample(MODE_ASSIGN, 0, -32768));
    queue_sample(make_sample(MODE_ASSIGN, 0, -32767));
    queue_sample(make_sample(MODE_CLASSIFY, 0, -1));
    s = make_sample(MODE_ASSIGN, 0, 0);
    s.f[0] = 16'sh5555;
    s.f[7] = 16'shAAAA;
    queue_sample(s);
    queue_sample(make_sample(MODE_UPDATE, 0, 0));
    queue_sample(make_sample(MODE_ASSIGN, 0, 32767));
    queue_sample(make_sample(MODE_UPDATE, 0, 0));       // unchanged centroid
    queue_sample(make_sample(MODE_UPDATE, 0, 0));
    // Unused components written but ignored with three features.
    run_phase(5'd4, 5'd3, 0, 0, 0, 0);
    queue_sample(make_sample(MODE_WRITE, 4'd12, 1234)); // beyond clusters in use
    queue_sample(make_sample(MODE_CLASSIFY, 0, 1234));
    queue_sample(make_sample(MODE_ASSIGN, 0, -7));

    // Random phases over settings, out-of-range values among them.
    run_phase(5'd16, 5'd8, 0, 0, 20, 0);
    run_phase(5'd0, 5'd0, 81, 0, 12, 0);
    run_phase(5'd31, 5'd31, 0, 81, 20, 0);
    run_phase(5'd1, 5'd1, 19, 19, 12, 0);
    run_phase(5'd5, 5'd15, 0, 0, 20, 1);
    run_phase(5'd2, 5'd9, 19, 19, 16, 0);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
